>>> rtl/core/nlp_pkg.sv
package nlp_pkg;

   localparam int DATA_W      = 32;
   localparam int MAX_LEN_DEF = 16;

   typedef struct packed {
      logic signed [DATA_W-1:0] in_value;
      logic                     in_last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     out_last;
      logic                     wrapped;
      logic                     overflow;
   } rsp_type;

   // read address source
   typedef enum logic {
      ADDR_SCAN,
      ADDR_EMIT
   } addr_sel_type;

   typedef struct packed {
      logic         load;      // store an accepted transaction
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         idx_init;  // scan index to last element
      logic         idx_dec;
      logic         prev_ld;
      logic         piv_ld;
      logic         succ_ld;
      logic         wrap_clr;
      logic         wrap_set;
      logic         k_clr;
      logic         k_inc;
      logic         out_valid;
      logic         list_clr;  // list done: count and overflow back to zero
   } cmd_type;

   typedef struct packed {
      logic short_list;  // fewer than two elements held
      logic idx_first;   // scan index on last element
      logic idx_zero;
      logic less;        // read element < right neighbor
      logic succ_hit;    // pivot < read element
      logic k_last;      // emitting final element
   } sts_type;

endpackage

>>> rtl/core/nlp_ram.sv
module nlp_ram
   #(
      parameter int WIDTH = 32,
      parameter int DEPTH = 16
   )
   (
      input  logic                     clock,
      input  logic                     we,
      input  logic [$clog2(DEPTH)-1:0] waddr,
      input  logic [WIDTH-1:0]         wdata,
      input  logic                     re,
      input  logic [$clog2(DEPTH)-1:0] raddr,
      output logic [WIDTH-1:0]         rdata
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/nlp_ctrl.sv
module nlp_ctrl
   import nlp_pkg::*;
   (
      input  logic    clock,
      input  logic    reset,
      input  logic    start,
      input  logic    in_last,
      input  sts_type sts,
      output cmd_type cmd,
      output logic    busy
   );

   typedef enum logic [2:0] {
      IDLE,
      SETUP,
      P_RD,
      P_CMP,
      S_RD,
      S_CMP,
      E_RD,
      E_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (in_last) begin
                  state_in = SETUP;
               end
            end
         end
         SETUP: begin
            cmd.idx_init = 1'b1;
            cmd.wrap_clr = 1'b1;
            if (sts.short_list) begin
               cmd.wrap_set = 1'b1;
               cmd.k_clr    = 1'b1;
               state_in     = E_RD;
            end else begin
               state_in = P_RD;
            end
         end
         P_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = P_CMP;
         end
         P_CMP: begin
            if (sts.idx_first) begin
               cmd.prev_ld = 1'b1;
               cmd.idx_dec = 1'b1;
               state_in    = P_RD;
            end else if (sts.less) begin
               cmd.piv_ld   = 1'b1;
               cmd.idx_init = 1'b1;
               state_in     = S_RD;
            end else if (sts.idx_zero) begin
               cmd.wrap_set = 1'b1;
               cmd.k_clr    = 1'b1;
               state_in     = E_RD;
            end else begin
               cmd.prev_ld = 1'b1;
               cmd.idx_dec = 1'b1;
               state_in    = P_RD;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (sts.succ_hit) begin
               cmd.succ_ld = 1'b1;
               cmd.k_clr   = 1'b1;
               state_in    = E_RD;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in    = S_RD;
            end
         end
         E_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_EMIT;
            state_in     = E_OUT;
         end
         E_OUT: begin
            cmd.out_valid = 1'b1;
            if (sts.k_last) begin
               cmd.list_clr = 1'b1;
               state_in     = IDLE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = E_RD;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

>>> rtl/core/nlp_dp.sv
module nlp_dp
   import nlp_pkg::*;
   #(
      parameter int MAX_LEN = MAX_LEN_DEF
   )
   (
      input  logic    clock,
      input  logic    reset,
      input  req_type req_data,
      input  cmd_type cmd,
      output sts_type sts,
      output logic    rsp_valid,
      output rsp_type rsp_data
   );

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int SW = IW + 2;

   logic [CW-1:0]            count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic                     wrap_ff, wrap_in;
   logic [IW-1:0]            idx_ff, idx_in;
   logic [IW-1:0]            k_ff, k_in;
   logic [IW-1:0]            piv_ff, piv_in;
   logic [IW-1:0]            succ_ff, succ_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic signed [DATA_W-1:0] pv_ff, pv_in;

   logic                     we;
   logic [IW-1:0]            raddr;
   logic [IW-1:0]            emit_addr;
   logic [IW-1:0]            last_idx;
   logic [SW-1:0]            mirror;
   logic [SW-1:0]            rev_all;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rd_value;

   assign we       = cmd.load && (count_ff < CW'(MAX_LEN));
   assign last_idx = IW'(count_ff - CW'(1));
   assign rd_value = $signed(rd_data);

   // output position k -> store address
   assign rev_all = SW'(count_ff) - SW'(1) - SW'(k_ff);
   assign mirror  = SW'(count_ff) + SW'(piv_ff) - SW'(k_ff);

   always_comb begin
      if (wrap_ff) begin
         emit_addr = IW'(rev_all);
      end else if (k_ff < piv_ff) begin
         emit_addr = k_ff;
      end else if (k_ff == piv_ff) begin
         emit_addr = succ_ff;
      end else if (IW'(mirror) == succ_ff) begin
         emit_addr = piv_ff;
      end else begin
         emit_addr = IW'(mirror);
      end
   end

   assign raddr = (cmd.addr_sel == ADDR_EMIT) ? emit_addr : idx_ff;

   nlp_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_LEN)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(IW'(count_ff)),
      .wdata(req_data.in_value),
      .re   (cmd.rd_en),
      .raddr(raddr),
      .rdata(rd_data)
   );

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      wrap_in  = wrap_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      piv_in   = piv_ff;
      succ_in  = succ_ff;
      prev_in  = prev_ff;
      pv_in    = pv_ff;
      if (cmd.load) begin
         if (we) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.list_clr) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
      if (cmd.wrap_clr) begin
         wrap_in = 1'b0;
      end
      if (cmd.wrap_set) begin
         wrap_in = 1'b1;
      end
      if (cmd.idx_init) begin
         idx_in = last_idx;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - IW'(1);
      end
      if (cmd.k_clr) begin
         k_in = '0;
      end else if (cmd.k_inc) begin
         k_in = k_ff + IW'(1);
      end
      if (cmd.prev_ld) begin
         prev_in = rd_value;
      end
      if (cmd.piv_ld) begin
         piv_in = idx_ff;
         pv_in  = rd_value;
      end
      if (cmd.succ_ld) begin
         succ_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         wrap_ff  <= 1'b0;
         idx_ff   <= '0;
         k_ff     <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         wrap_ff  <= wrap_in;
         idx_ff   <= idx_in;
         k_ff     <= k_in;
      end
      piv_ff  <= piv_in;
      succ_ff <= succ_in;
      prev_ff <= prev_in;
      pv_ff   <= pv_in;
   end

   assign sts.short_list = (count_ff < CW'(2));
   assign sts.idx_first  = (idx_ff == last_idx);
   assign sts.idx_zero   = (idx_ff == '0);
   assign sts.less       = (rd_value < prev_ff);
   assign sts.succ_hit   = (pv_ff < rd_value);
   assign sts.k_last     = (k_ff == last_idx);

   assign rsp_valid          = cmd.out_valid;
   assign rsp_data.out_value = rd_value;
   assign rsp_data.out_last  = sts.k_last;
   assign rsp_data.wrapped   = wrap_ff;
   assign rsp_data.overflow  = ovf_ff;

endmodule

>>> rtl/core/next_lexicographic_permutation_top.sv
// Channel  Ports                          Handshake
// -------  -----------------------------  ----------------------------------------
// request  start, busy, req_data          taken on a clock edge with start & !busy
// result   rsp_valid, rsp_data            one strobe per element, no back-pressure
//
// Loading accepts an element on each edge with start high; busy stays low until
// the element that carries in_last. After it the block stays busy through a
// setup step, the pivot and successor scans as the list needs them, and the
// emission of all n elements: every scan or emission step is one read of the
// element RAM plus one compare or output, so results are never back-to-back.
// Reset clears the FSM, the element count and the overflow flag; the RAM contents
// are not cleared. The receiver cannot stall; results are dropped if not taken in their cycle.
module next_lexicographic_permutation_top
   import nlp_pkg::*;
   #(
      parameter int MAX_LEN = MAX_LEN_DEF
   )
   (
      input  logic    clock,
      input  logic    reset,
      input  logic    start,
      output logic    busy,
      input  req_type req_data,
      output logic    rsp_valid,
      output rsp_type rsp_data
   );

   // controller <-> datapath
   cmd_type cmd;
   sts_type sts;

   // FSM walks: load -> pivot scan (right to left) -> successor scan
   // (right to left, skipped if there is no pivot) -> emission. The swap and
   // suffix reversal are never written back; the datapath remaps each output
   // position to a RAM address instead.
   nlp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .in_last(req_data.in_last),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   nlp_dp #(
      .MAX_LEN(MAX_LEN)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/core/nlp_checker.sv
module nlp_checker
   import nlp_pkg::*;
   (
      input logic    clock,
      input logic    reset,
      input logic    start,
      input logic    busy,
      input req_type req_data,
      input logic    rsp_valid,
      input rsp_type rsp_data
   );

   // results only while a list is being processed
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside busy window");

   // results are never back-to-back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.in_last) |=> !busy)
      else $error("busy after non-final transaction");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.in_last) |=> busy)
      else $error("not busy after final transaction");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_last) |=> !busy)
      else $error("still busy after final result");

endmodule

bind next_lexicographic_permutation_top nlp_checker u_nlp_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);

>>> sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nlp_pkg::*;

   localparam int LIST_CAP = MAX_LEN_DEF;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int ITEM_TARGET  = 230;
   localparam int MISMATCH_LOG = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   next_lexicographic_permutation_top #(
      .MAX_LEN(LIST_CAP)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus waiting to go out, and results the permutation predictor expects.
   req_type pending_items[$];
   rsp_type expected_perm[$];

   // Predictor copy of the list being loaded.
   logic signed [DATA_W-1:0] held_vals[LIST_CAP];
   int unsigned held_count   = 0;
   bit          held_dropped = 1'b0;

   int item_total     = 0;
   int accepted_total = 0;
   int fail_count     = 0;
   int sender_idle_pct;

   // Store one accepted element; on the closing element compute the next
   // permutation and queue one expected result per held element.
   task automatic load_and_permute(input req_type item);
      int      pivot;
      int      i;
      int      lo;
      int      hi;
      bit      wrap;
      logic signed [DATA_W-1:0] tmp;
      rsp_type r;
      begin
         if (held_count < LIST_CAP) begin
            held_vals[held_count] = item.in_value;
            held_count++;
         end else begin
            held_dropped = 1'b1;   // beyond capacity: dropped, flag sticks
         end
         if (item.in_last) begin
            // pivot: rightmost element strictly below its right neighbor
            pivot = -1;
            for (i = int'(held_count) - 1; i > 0; i--) begin
               if (held_vals[i-1] < held_vals[i]) begin
                  pivot = i - 1;
                  break;
               end
            end
            wrap = (pivot < 0);
            if (!wrap) begin
               // swap with the rightmost strictly larger element
               for (i = int'(held_count) - 1; i > pivot; i--) begin
                  if (held_vals[pivot] < held_vals[i]) begin
                     tmp              = held_vals[i];
                     held_vals[i]     = held_vals[pivot];
                     held_vals[pivot] = tmp;
                     break;
                  end
               end
            end
            // reverse the suffix, or the whole list when wrapping
            lo = wrap ? 0 : pivot + 1;
            hi = int'(held_count) - 1;
            while (lo < hi) begin
               tmp           = held_vals[lo];
               held_vals[lo] = held_vals[hi];
               held_vals[hi] = tmp;
               lo++;
               hi--;
            end
            for (i = 0; i < int'(held_count); i++) begin
               r.out_value = held_vals[i];
               r.out_last  = (i == int'(held_count) - 1);
               r.wrapped   = wrap;
               r.overflow  = held_dropped;
               expected_perm.insert(expected_perm.size(), r);
            end
            held_count   = 0;
            held_dropped = 1'b0;
         end
      end
   endtask

   task automatic push_item(input logic signed [DATA_W-1:0] v, input bit last);
      req_type r;
      begin
         r.in_value = v;
         r.in_last  = last;
         pending_items.insert(pending_items.size(), r);
         item_total++;
      end
   endtask

   // Random element by list style: full range, small (lots of duplicates),
   // descending run (forces the wrap path), or extreme values.
   function automatic logic signed [DATA_W-1:0] pick_value(input int style,
                                                          input logic signed [DATA_W-1:0] prev);
      logic signed [DATA_W-1:0] v;
      begin
         case (style)
            0: v = $urandom;
            1: v = $signed($urandom_range(6)) - 3;
            2: v = prev - $signed($urandom_range(3));
            default: begin
               case ($urandom_range(6))
                  0: v = VAL_MIN;
                  1: v = VAL_MIN + 1;
                  2: v = -1;
                  3: v = 0;
                  4: v = 1;
                  5: v = VAL_MAX - 1;
                  default: v = VAL_MAX;
               endcase
            end
         endcase
         return v;
      end
   endfunction

   // Random list: mostly short, some at full capacity, some past it so the
   // overflow flag and dropped elements get exercised.
   task automatic push_random_list();
      int len;
      int style;
      int k;
      logic signed [DATA_W-1:0] v;
      begin
         case ($urandom_range(9))
            0:       len = $urandom_range(LIST_CAP + 4, LIST_CAP + 1);
            1:       len = LIST_CAP;
            default: len = $urandom_range(8, 1);
         endcase
         style = $urandom_range(3);
         v     = $signed($urandom_range(2000)) - 1000;
         for (k = 0; k < len; k++) begin
            v = pick_value(style, v);
            push_item(v, k == len - 1);
         end
      end
   endtask

   // Sender idle rate by phase: light, then heavy, then back-to-back.
   always_comb begin
      if (accepted_total < ITEM_TARGET / 3)
         sender_idle_pct = 21;
      else if (accepted_total < 2 * ITEM_TARGET / 3)
         sender_idle_pct = 79;
      else
         sender_idle_pct = 0;
   end

   // Driver: a transaction is taken on an edge with start high and busy low.
   // The predictor runs on that same edge, then the next item (if any) is
   // presented unless this cycle is chosen as an idle one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            load_and_permute(req_data);
            void'(pending_items.pop_front());
            accepted_total++;
         end
         if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_items[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: results last one cycle and cannot be held off, so every
   // strobe is checked against the oldest expectation right away.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_perm.size() == 0) begin
            fail_count++;
            if (fail_count <= MISMATCH_LOG)
               $display("ERROR: unexpected result value=%0d last=%0b wrap=%0b ovf=%0b",
                        rsp_data.out_value, rsp_data.out_last, rsp_data.wrapped,
                        rsp_data.overflow);
         end else begin
            want = expected_perm.pop_front();
            if (rsp_data.out_value !== want.out_value || rsp_data.out_last !== want.out_last
                || rsp_data.wrapped !== want.wrapped || rsp_data.overflow !== want.overflow) begin
               fail_count++;
               if (fail_count <= MISMATCH_LOG)
                  $display("ERROR: exp %0d l=%0b w=%0b o=%0b, got %0d l=%0b w=%0b o=%0b",
                           want.out_value, want.out_last, want.wrapped, want.overflow,
                           rsp_data.out_value, rsp_data.out_last, rsp_data.wrapped,
                           rsp_data.overflow);
            end
         end
      end
   end

   initial begin
      // single element: no pivot, comes back unchanged with wrap set
      push_item(7, 1'b1);
      // ascending extremes: pivot at the front, swap only
      push_item(VAL_MIN, 1'b0);
      push_item(VAL_MAX, 1'b1);
      // descending extremes: last permutation, wraps to ascending
      push_item(VAL_MAX, 1'b0);
      push_item(VAL_MIN, 1'b1);
      // 1 3 2 -> 2 1 3: swap then suffix reversal
      push_item(1, 1'b0);
      push_item(3, 1'b0);
      push_item(2, 1'b1);
      // all equal: strict compare finds no pivot
      push_item(2, 1'b0);
      push_item(2, 1'b0);
      push_item(2, 1'b1);
      // duplicates in the suffix: 1 2 2 -> 2 1 2
      push_item(1, 1'b0);
      push_item(2, 1'b0);
      push_item(2, 1'b1);
      // sign matters: -1 0 -1 -> 0 -1 -1
      push_item(-1, 1'b0);
      push_item(0, 1'b0);
      push_item(-1, 1'b1);
      // mixed signs and extremes
      push_item(0, 1'b0);
      push_item(-1, 1'b0);
      push_item(VAL_MAX, 1'b0);
      push_item(VAL_MIN, 1'b1);

      while (item_total < ITEM_TARGET)
         push_random_list();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent and every expected result seen
      while (pending_items.size() != 0 || expected_perm.size() != 0)
         @(posedge clock);
      // then wait on to catch any stray result
      repeat (100) @(posedge clock);

      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2ms;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
